@@ design/fsmatch_pkg.sv @@
// Shared types, codes and helpers for the folded substring matcher.
// No dependencies; used by fsmatch_cell and folded_substring_matcher.
package fsmatch_pkg;

  // Input function codes
  typedef enum logic {
    FUNC_QUERY = 1'b0,
    FUNC_NAME  = 1'b1
  } func_t;

  // Register indexes (byte address 4*index)
  typedef enum logic {
    REG_EXACT_MATCH = 1'b0,
    REG_MATCH_CASE  = 1'b1
  } reg_idx_t;

  // ASCII folding constants
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Per-beat controls broadcast to every cell
  typedef struct packed {
    logic shift;  // query beat: take byte and active bit from upper neighbor
    logic step;   // name beat: advance prefix hits
    logic clear;  // drop partial name state
    logic fold;   // fold uppercase before compare
  } cell_ctrl_t;

  // Fold ASCII A-Z to lowercase when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && (b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ design/fsmatch_cell.sv @@
// One cell of the match chain: one query byte, its active bit and its prefix hit.
// Depends on fsmatch_pkg.
module fsmatch_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fsmatch_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]              name_byte_i,  // folded name byte
  input  logic [7:0]              q_in_i,       // query byte from upper neighbor
  input  logic                    act_in_i,     // active bit from upper neighbor
  input  logic                    prev_pass_i,  // lower neighbor's hit (1 when inactive)
  output logic [7:0]              q_o,
  output logic                    act_o,
  output logic                    pass_o,
  output logic                    hit_nxt_o
);

  logic [7:0] q_r, q_nxt;
  logic       act_r, act_nxt;
  logic       hit_r, hit_nxt;
  logic       eq;

  // Compare stored query byte with the name byte
  assign eq        = (fsmatch_pkg::fold_byte(q_r, ctrl_i.fold) == name_byte_i);
  assign hit_nxt_o = act_r && prev_pass_i && eq;

  // Next state
  always_comb begin
    q_nxt   = ctrl_i.shift ? q_in_i : q_r;
    act_nxt = ctrl_i.shift ? act_in_i : act_r;
    hit_nxt = hit_r;
    if (ctrl_i.clear) begin
      hit_nxt = 1'b0;
    end else if (ctrl_i.step) begin
      hit_nxt = hit_nxt_o;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      hit_r <= hit_nxt;
    end
  end

  // Query byte, no reset
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o    = q_r;
  assign act_o  = act_r;
  assign pass_o = !act_r || hit_r;

endmodule

@@ design/folded_substring_matcher.sv @@
// Top level of the folded substring matcher: config registers, control, cell chain.
// Depends on fsmatch_pkg and fsmatch_cell.
//
//  channel | direction | ports                                        | moves
//  in      | input     | in_valid/in_ready, func, data_byte, last_byte | query or name byte
//  out     | output    | out_valid/out_ready, matched, query_overflow  | one beat per name
//  cfg     | APB       | psel/penable/pwrite/paddr/pwdata/prdata       | exact_match, match_case
//
// One input beat per cycle while in_ready is high; the result of a name is registered and
// shows in the cycle after its last byte. The query sits in a chain of MAX_QUERY cells,
// packed at the top end; each name byte advances every cell's prefix hit at once.
// Synchronous active-low reset empties the query and clears the name state.
// in_ready drops only while a result waits and out_ready is low.
module folded_substring_matcher #(
  parameter int MAX_QUERY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_matched,
  output logic        out_query_overflow,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = $clog2(MAX_QUERY + 1);
  localparam int NW = $clog2(MAX_QUERY + 2);
  localparam logic [NW-1:0] NLEN_SAT = NW'(MAX_QUERY + 1);

  // Configuration registers
  logic exact_r, exact_nxt;
  logic case_r, case_nxt;
  logic cfg_wr;
  fsmatch_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = fsmatch_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    exact_nxt = exact_r;
    case_nxt  = case_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        fsmatch_pkg::REG_EXACT_MATCH: exact_nxt = pwdata[0];
        fsmatch_pkg::REG_MATCH_CASE:  case_nxt  = pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      fsmatch_pkg::REG_EXACT_MATCH: prdata[0] = exact_r;
      fsmatch_pkg::REG_MATCH_CASE:  prdata[0] = case_r;
      default: ;
    endcase
  end

  // Control state
  logic          loading_r, loading_nxt;
  logic          ovf_r, ovf_nxt;
  logic [QW-1:0] qlen_r, qlen_nxt;
  logic [NW-1:0] nlen_r, nlen_nxt, nlen_inc;
  logic          found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_matched_r, out_matched_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic in_acc, query_beat, name_beat, restart, full, result;
  fsmatch_pkg::cell_ctrl_t ctrl;
  logic [7:0] name_byte;

  // Chain wiring
  logic [7:0] q_vec   [MAX_QUERY];
  logic       act_vec [MAX_QUERY];
  logic       pass_vec[MAX_QUERY];
  logic       hitn_vec[MAX_QUERY];
  logic [MAX_QUERY-1:0] act_bits;

  assign in_ready   = !out_valid_r || out_ready;
  assign in_acc     = in_valid && in_ready;
  assign query_beat = in_acc && (fsmatch_pkg::func_t'(in_func) == fsmatch_pkg::FUNC_QUERY);
  assign name_beat  = in_acc && (fsmatch_pkg::func_t'(in_func) == fsmatch_pkg::FUNC_NAME);
  assign restart    = !loading_r;
  assign full       = act_vec[0];
  assign result     = name_beat && in_last_byte;
  assign name_byte  = fsmatch_pkg::fold_byte(in_data_byte, !case_r);

  // Broadcast controls
  always_comb begin
    ctrl.shift = query_beat && (restart || !full);
    ctrl.step  = name_beat;
    ctrl.clear = query_beat || result;
    ctrl.fold  = !case_r;
  end

  // Cell chain: query shifts in at the top; hits pass upward
  for (genvar k = 0; k < MAX_QUERY; k++) begin : g_cell
    logic [7:0] q_src;
    logic       act_src;
    logic       prev_pass;
    if (k == MAX_QUERY - 1) begin : g_top
      assign q_src   = in_data_byte;
      assign act_src = 1'b1;
    end else begin : g_mid
      assign q_src   = q_vec[k+1];
      assign act_src = !restart && act_vec[k+1];
    end
    if (k == 0) begin : g_bot
      assign prev_pass = 1'b1;
    end else begin : g_up
      assign prev_pass = pass_vec[k-1];
    end
    assign act_bits[k] = act_vec[k];

    fsmatch_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl_i      (ctrl),
      .name_byte_i (name_byte),
      .q_in_i      (q_src),
      .act_in_i    (act_src),
      .prev_pass_i (prev_pass),
      .q_o         (q_vec[k]),
      .act_o       (act_vec[k]),
      .pass_o      (pass_vec[k]),
      .hit_nxt_o   (hitn_vec[k])
    );
  end

  // Query length, overflow, name tracking and result
  always_comb begin
    loading_nxt     = loading_r;
    ovf_nxt         = ovf_r;
    qlen_nxt        = qlen_r;
    nlen_nxt        = nlen_r;
    found_nxt       = found_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_matched_nxt = out_matched_r;
    out_ovf_nxt     = out_ovf_r;
    nlen_inc        = (nlen_r == NLEN_SAT) ? nlen_r : nlen_r + NW'(1);

    if (query_beat) begin
      loading_nxt = !in_last_byte;
      nlen_nxt    = '0;
      found_nxt   = 1'b0;
      if (restart) begin
        qlen_nxt = QW'(1);
        ovf_nxt  = 1'b0;
      end else if (full) begin
        ovf_nxt  = 1'b1;
      end else begin
        qlen_nxt = qlen_r + QW'(1);
      end
    end else if (name_beat) begin
      loading_nxt = 1'b0;
      nlen_nxt    = nlen_inc;
      found_nxt   = found_r || hitn_vec[MAX_QUERY-1];
      if (in_last_byte) begin
        nlen_nxt        = '0;
        found_nxt       = 1'b0;
        out_valid_nxt   = 1'b1;
        out_ovf_nxt     = ovf_r;
        if (ovf_r || (qlen_r == '0)) begin
          out_matched_nxt = 1'b0;
        end else if (exact_r) begin
          out_matched_nxt = hitn_vec[MAX_QUERY-1] && (nlen_inc == NW'(qlen_r));
        end else begin
          out_matched_nxt = found_r || hitn_vec[MAX_QUERY-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_r     <= 1'b0;
      case_r      <= 1'b0;
      loading_r   <= 1'b0;
      ovf_r       <= 1'b0;
      qlen_r      <= '0;
      nlen_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      exact_r     <= exact_nxt;
      case_r      <= case_nxt;
      loading_r   <= loading_nxt;
      ovf_r       <= ovf_nxt;
      qlen_r      <= qlen_nxt;
      nlen_r      <= nlen_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_matched        = out_matched_r;
  assign out_query_overflow = out_ovf_r;

  // Assertions
  a_qlen_tracks_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(act_bits) == int'(qlen_r))
    else $error("query length does not match active cells");

  a_ovf_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> act_vec[0])
    else $error("overflow set with chain not full");

  a_result_from_name_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) ##1 out_valid_r |->
      $past(in_valid && in_ready && in_last_byte &&
            (fsmatch_pkg::func_t'(in_func) == fsmatch_pkg::FUNC_NAME)))
    else $error("result beat without a finished name");

  a_no_match_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_matched_r && out_ovf_r))
    else $error("match reported with overflowed query");

endmodule
